@@ design/trinomial_american_option_pricer_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef TRINOMIAL_AMERICAN_OPTION_PRICER_MACROS_SVH
`define TRINOMIAL_AMERICAN_OPTION_PRICER_MACROS_SVH

// Implication in the next cycle, off during reset.
`define TAOP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication in the same cycle, checked during reset too.
`define TAOP_ASSERT_NOW(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/taop_pkg.sv @@
// Shared types, constants and arithmetic helpers of the trinomial option pricer.
package taop_pkg;

  localparam int unsigned DefMaxSteps = 64;
  localparam logic [31:0] OneQ30 = 32'h4000_0000;
  localparam logic [31:0] Sat32  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REG_UP_MULT     = 3'd0,
    REG_DOWN_FACTOR = 3'd1,
    REG_UP_PROB     = 3'd2,
    REG_DOWN_PROB   = 3'd3,
    REG_DISCOUNT    = 3'd4,
    REG_STRIKE      = 3'd5,
    REG_DIVISIONS   = 3'd6
  } cfg_reg_t;

  localparam logic OpCall = 1'b0;
  localparam logic OpPut  = 1'b1;

  function automatic logic [31:0] sat32(input logic [34:0] v);
    sat32 = (v > {3'b000, Sat32}) ? Sat32 : v[31:0];
  endfunction

  function automatic logic [31:0] exercise(input logic [31:0] price,
                                           input logic [31:0] strike,
                                           input logic        is_put);
    logic [31:0] r;
    if (is_put == OpPut) begin
      r = (strike > price) ? strike - price : 32'd0;
    end else begin
      r = (price > strike) ? price - strike : 32'd0;
    end
    exercise = r;
  endfunction

endpackage

@@ design/trinomial_american_option_pricer.sv @@
// Trinomial American option pricer: backward induction on one shared multiplier.
// Usage:
//   Write the seven set-up registers through cfg_we / cfg_index / cfg_data while
//   the block is idle. Send one word on s_axis: tdata = initial price (Q16.16),
//   tuser = kind (0 call, 1 put). One word comes back on m_axis: the option
//   value at the root (Q16.16, saturated).
//   Order of work for N steps: the root, then per step one up and one down price
//   with their leaves; then for each of the N levels the set-up states LV0, LV1,
//   LV2 and, for each node, MU, MM, MD, DISC, WR, N*N nodes in all; then FIN and
//   OUT read the root out. The single 32x32 multiplier serves every product.
//   s_axis_tready is high only while idle; one item is worked at a time.
//   The result sits in an output register; a stalled receiver leaves it there,
//   and the next item may be accepted meanwhile, but its result waits until
//   the register is free.
//   Reset (rst, synchronous) returns registers to their defaults (factors and
//   discount 1.0, probabilities and strike 0, one step), drops any item in
//   flight and any pending result. Node memories are not cleared.
module trinomial_american_option_pricer
  import taop_pkg::*;
#(
  parameter int unsigned MAX_STEPS = DefMaxSteps
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] initial_price
  input  logic        s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] option_value
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned Nodes = 2 * MAX_STEPS + 1;
  localparam int unsigned IW    = $clog2(Nodes);
  localparam int unsigned NW    = $clog2(MAX_STEPS + 1);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_ROOT = 15'b000000000000010,
    S_PUP  = 15'b000000000000100,
    S_WUP  = 15'b000000000001000,
    S_WDN  = 15'b000000000010000,
    S_LV0  = 15'b000000000100000,
    S_LV1  = 15'b000000001000000,
    S_LV2  = 15'b000000010000000,
    S_MU   = 15'b000000100000000,
    S_MM   = 15'b000001000000000,
    S_MD   = 15'b000010000000000,
    S_DISC = 15'b000100000000000,
    S_WR   = 15'b001000000000000,
    S_FIN  = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_t;

  state_t state;

  logic [31:0] up_mult, down_factor, discount, strike;
  logic [30:0] up_probability, down_probability;
  logic [6:0]  divisions;

  logic [31:0] s0;
  logic        is_put;
  logic [NW-1:0] n;
  logic [NW-1:0] level_counter;
  logic [IW-1:0] j, lo, hi;
  logic [31:0] up_run, dn_run;
  logic [31:0] up_v, mid_v, below_v;
  logic [34:0] acc;
  logic [33:0] prod_q;

  logic [31:0] node_values [Nodes];
  logic [31:0] node_prices [Nodes];
  logic [31:0] val_rd, price_rd;

  // middle probability, clamped at zero
  logic [31:0] pud, pm;
  assign pud = {1'b0, up_probability} + {1'b0, down_probability};
  assign pm  = (pud >= OneQ30) ? 32'd0 : OneQ30 - pud;

  logic [IW-1:0] n_ix;
  assign n_ix = IW'(n);

  logic [NW-1:0] n_eff;
  assign n_eff = (32'(divisions) > MAX_STEPS) ? NW'(MAX_STEPS) : NW'(divisions);

  // shared multiplier, Q16.16 x Q2.30 truncated
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [33:0] mul_q;
  always_comb begin
    case (state)
      S_PUP:   begin mul_a = up_run;     mul_b = up_mult; end
      S_WUP:   begin mul_a = dn_run;     mul_b = down_factor; end
      S_MU:    begin mul_a = val_rd;     mul_b = {1'b0, up_probability}; end
      S_MM:    begin mul_a = mid_v;      mul_b = pm; end
      S_MD:    begin mul_a = below_v;    mul_b = {1'b0, down_probability}; end
      S_DISC:  begin mul_a = sat32(acc); mul_b = discount; end
      default: begin mul_a = 32'd0;      mul_b = 32'd0; end
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign mul_q = mul_p[63:30];

  // node value of the fold
  logic [31:0] cont, ex_fold, fold_val;
  assign cont     = sat32({1'b0, prod_q});
  assign ex_fold  = exercise(price_rd, strike, is_put);
  assign fold_val = (ex_fold > cont) ? ex_fold : cont;

  // memory write side
  logic          pw_en, vw_en;
  logic [IW-1:0] w_addr;
  logic [31:0]   pw_data, vw_data;
  always_comb begin
    pw_en   = 1'b0;
    vw_en   = 1'b0;
    w_addr  = j;
    pw_data = up_run;
    case (state)
      S_ROOT: begin pw_en = 1'b1; w_addr = n_ix;     pw_data = s0; end
      S_WUP:  begin pw_en = 1'b1; w_addr = n_ix + j; pw_data = up_run; end
      S_WDN:  begin pw_en = 1'b1; w_addr = n_ix - j; pw_data = dn_run; end
      default: ;
    endcase
    vw_en   = pw_en || (state == S_WR);
    vw_data = (state == S_WR) ? fold_val : exercise(pw_data, strike, is_put);
  end

  // memory read side
  logic          vr_en, pr_en;
  logic [IW-1:0] vr_addr, pr_addr;
  always_comb begin
    vr_en   = 1'b0;
    pr_en   = 1'b0;
    vr_addr = j;
    pr_addr = j;
    case (state)
      S_LV0: begin vr_en = 1'b1; vr_addr = lo - IW'(1); end
      S_LV1: begin vr_en = 1'b1; vr_addr = lo; end
      S_LV2: begin vr_en = 1'b1; vr_addr = j + IW'(1); pr_en = 1'b1; pr_addr = j; end
      S_WR:  begin
        vr_en   = (j != hi);
        vr_addr = j + IW'(2);
        pr_en   = (j != hi);
        pr_addr = j + IW'(1);
      end
      S_FIN: begin vr_en = 1'b1; vr_addr = n_ix; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pw_en) node_prices[w_addr] <= pw_data;
    if (vw_en) node_values[w_addr] <= vw_data;
    if (pr_en) price_rd <= node_prices[pr_addr];
    if (vr_en) val_rd   <= node_values[vr_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      up_mult          <= OneQ30;
      down_factor      <= OneQ30;
      up_probability   <= 31'd0;
      down_probability <= 31'd0;
      discount         <= OneQ30;
      strike           <= 32'd0;
      divisions        <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UP_MULT:     up_mult          <= cfg_data;
        REG_DOWN_FACTOR: down_factor      <= cfg_data;
        REG_UP_PROB:     up_probability   <= cfg_data[30:0];
        REG_DOWN_PROB:   down_probability <= cfg_data[30:0];
        REG_DISCOUNT:    discount         <= cfg_data;
        REG_STRIKE:      strike           <= cfg_data;
        REG_DIVISIONS:   divisions        <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      level_counter <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            s0     <= s_axis_tdata;
            up_run <= s_axis_tdata;
            dn_run <= s_axis_tdata;
            is_put <= s_axis_tuser;
            n      <= n_eff;
            state  <= S_ROOT;
          end
        end
        S_ROOT: begin
          j     <= IW'(1);
          state <= (n == '0) ? S_FIN : S_PUP;
        end
        S_PUP: begin
          up_run <= sat32({1'b0, mul_q});
          state  <= S_WUP;
        end
        S_WUP: begin
          dn_run <= sat32({1'b0, mul_q});
          state  <= S_WDN;
        end
        S_WDN: begin
          if (j == n_ix) begin
            level_counter <= n - NW'(1);
            lo    <= IW'(1);
            hi    <= (n_ix << 1) - IW'(1);
            j     <= IW'(1);
            state <= S_LV0;
          end else begin
            j     <= j + IW'(1);
            state <= S_PUP;
          end
        end
        S_LV0: state <= S_LV1;
        S_LV1: begin
          below_v <= val_rd;
          state   <= S_LV2;
        end
        S_LV2: begin
          mid_v <= val_rd;
          state <= S_MU;
        end
        S_MU: begin
          up_v  <= val_rd;
          acc   <= {1'b0, mul_q};
          state <= S_MM;
        end
        S_MM: begin
          acc   <= acc + {1'b0, mul_q};
          state <= S_MD;
        end
        S_MD: begin
          acc   <= acc + {1'b0, mul_q};
          state <= S_DISC;
        end
        S_DISC: begin
          prod_q <= mul_q;
          state  <= S_WR;
        end
        S_WR: begin
          // shift the window: old middle becomes the lower neighbor
          below_v <= mid_v;
          mid_v   <= up_v;
          if (j != hi) begin
            j     <= j + IW'(1);
            state <= S_MU;
          end else if (level_counter == '0) begin
            state <= S_FIN;
          end else begin
            level_counter <= level_counter - NW'(1);
            lo    <= lo + IW'(1);
            hi    <= hi - IW'(1);
            j     <= lo + IW'(1);
            state <= S_LV0;
          end
        end
        S_FIN: state <= S_OUT;
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= val_rd;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/taop_checker.sv @@
// Port-level checker for the trinomial option pricer, bound to the top level.
`include "trinomial_american_option_pricer_macros.svh"

module taop_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // a stalled result word holds
  `TAOP_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata), "result word dropped or changed")
  // an accepted word keeps the block busy
  `TAOP_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready,
                    !s_axis_tready, "input taken while busy")
  // a result never appears right after an accept
  `TAOP_ASSERT_NEXT(a_no_instant_result, clk, rst,
                    s_axis_tvalid && s_axis_tready && !m_axis_tvalid,
                    !m_axis_tvalid, "result without work")
  // reset empties the output register
  `TAOP_ASSERT_NOW(a_reset_clears, clk, $past(rst), !m_axis_tvalid,
                   "result valid after reset")

endmodule

bind trinomial_american_option_pricer taop_checker u_taop_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ bench/trinomial_american_option_pricer_test.sv @@
// Self-checking testbench for the trinomial American option pricer.
`timescale 1ns / 100ps

module trinomial_american_option_pricer_test;
  import taop_pkg::*;

  localparam int          TreeMax   = DefMaxSteps;
  localparam int          CycleCap  = 10_000_000;
  localparam logic [2:0]  RegUnused = 3'd7;
  localparam logic [31:0] Q30One    = 32'h4000_0000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // shadow copy of the set-up registers
  logic [31:0] sh_up, sh_down, sh_disc, sh_strike;
  logic [30:0] sh_pu, sh_pd;
  logic [6:0]  sh_steps;

  logic [31:0] value_queue[$];
  int          errors = 0;
  int          cycles = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  bit          rx_steady = 1'b0;

  trinomial_american_option_pricer u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] qmul(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p >> 30;
  endfunction

  function automatic logic [31:0] clip32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] payoff(logic [31:0] px, logic kind);
    if (kind == OpPut) return (sh_strike > px) ? sh_strike - px : 32'd0;
    return (px > sh_strike) ? px - sh_strike : 32'd0;
  endfunction

  // backward induction over the tree, in place
  function automatic logic [31:0] price_option(logic [31:0] s0, logic kind);
    logic [31:0] px[0:2*TreeMax];
    logic [31:0] val[0:2*TreeMax];
    logic [63:0] pud, sum;
    logic [31:0] pm, below, mid, cont, ex;
    int n, lo, hi;
    n = (sh_steps > TreeMax) ? TreeMax : int'(sh_steps);
    pud = {33'd0, sh_pu} + {33'd0, sh_pd};
    pm = (pud >= {32'd0, Q30One}) ? 32'd0 : Q30One - pud[31:0];
    px[n] = s0;
    for (int j = 1; j <= n; j++) begin
      px[n + j] = clip32(qmul(px[n + j - 1], sh_up));
      px[n - j] = clip32(qmul(px[n - j + 1], sh_down));
    end
    for (int j = 0; j <= 2 * n; j++) val[j] = payoff(px[j], kind);
    for (int k = n; k > 0; k--) begin
      lo = n - (k - 1);
      hi = n + (k - 1);
      below = val[lo - 1];
      for (int j = lo; j <= hi; j++) begin
        mid = val[j];
        sum = qmul(val[j + 1], {1'b0, sh_pu}) + qmul(mid, pm) + qmul(below, {1'b0, sh_pd});
        cont = clip32(qmul(clip32(sum), sh_disc));
        ex = payoff(px[j], kind);
        below = mid;
        val[j] = (ex > cont) ? ex : cont;
      end
    end
    return val[n];
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
    return 0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: check each accepted word, then pick the next ready
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (value_queue.size() == 0) begin
        $error("option_value: no word expected, got %h", m_axis_tdata);
        errors++;
      end else begin
        want = value_queue.pop_front();
        if (m_axis_tdata !== want) begin
          $error("option_value: expected %h, got %h", want, m_axis_tdata);
          errors++;
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_steady) stall_left = pick_gap();
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_UP_MULT:     sh_up = data;
      REG_DOWN_FACTOR: sh_down = data;
      REG_UP_PROB:     sh_pu = data[30:0];
      REG_DOWN_PROB:   sh_pd = data[30:0];
      REG_DISCOUNT:    sh_disc = data;
      REG_STRIKE:      sh_strike = data;
      REG_DIVISIONS:   sh_steps = data[6:0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [31:0] up, logic [31:0] dn, logic [31:0] pu, logic [31:0] pd,
                       logic [31:0] disc, logic [31:0] k, logic [31:0] steps);
    write_reg(REG_UP_MULT, up);
    write_reg(REG_DOWN_FACTOR, dn);
    write_reg(REG_UP_PROB, pu);
    write_reg(REG_DOWN_PROB, pd);
    write_reg(REG_DISCOUNT, disc);
    write_reg(REG_STRIKE, k);
    write_reg(REG_DIVISIONS, steps);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // valid stays high across back-to-back words; lowered only before a gap or in drain
  task automatic send_word(logic [31:0] s0, logic kind, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s0;
    s_axis_tuser <= kind;
    do @(posedge clk); while (!s_axis_tready);
    value_queue.push_back(price_option(s0, kind));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (value_queue.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_defaults();
    send_word(32'h0064_0000, OpCall);
    send_word(32'h0064_0000, OpPut);
    send_word(32'hFFFF_FFFF, OpCall);
    drain();
  endtask

  task automatic test_directed();
    // plain tree, prices around the strike
    setup(32'h4147_AE14, 32'h3EBF_D66E, 32'h1333_3333, 32'h1333_3333,
          32'h3FEF_9DB2, 32'h0064_0000, 4);
    send_word(32'h0064_0000, OpCall);
    send_word(32'h0064_0000, OpPut);
    send_word(32'h0000_0000, OpPut);
    send_word(32'hFFFF_FFFF, OpCall);
    send_word(32'h0050_0000, OpPut);
    drain();
    // no steps: root is a leaf; unknown index must be ignored
    setup(32'h4147_AE14, 32'h3EBF_D66E, 32'h1333_3333, 32'h1333_3333,
          32'h3FEF_9DB2, 32'h0064_0000, 0);
    write_reg(RegUnused, 32'h0000_0005);
    @(posedge clk);
    cfg_we <= 1'b0;
    send_word(32'h0070_0000, OpCall);
    send_word(32'h0070_0000, OpPut);
    drain();
    // probabilities above one, factor and discount at full scale: saturation
    setup(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'hFFFF_FFFF, 32'h0000_0000, 3);
    send_word(32'h8000_0000, OpCall);
    send_word(32'hFFFF_FFFF, OpPut);
    drain();
    setup(32'h8000_0000, 32'h2000_0000, 32'h4000_0000, 32'h0000_0000,
          32'hFFFF_FFFF, 32'hFFFF_FFFF, 2);
    send_word(32'h0001_0000, OpPut);
    send_word(32'hFFFF_0000, OpCall);
    drain();
    // step count above the maximum saturates
    setup(32'h4051_EB85, 32'h3FAE_8F5C, 32'h1555_5555, 32'h1555_5555,
          32'h3FFD_70A4, 32'h0064_0000, 127);
    send_word(32'h0064_0000, OpPut);
    drain();
    setup(32'h4051_EB85, 32'h3FAE_8F5C, 32'h1555_5555, 32'h1555_5555,
          32'h3FFD_70A4, 32'h0064_0000, 64);
    send_word(32'h005A_0000, OpCall);
    drain();
  endtask

  task automatic test_backpressure();
    setup(32'h4147_AE14, 32'h3EBF_D66E, 32'h1333_3333, 32'h1333_3333,
          32'h3FEF_9DB2, 32'h0064_0000, 2);
    hold_req <= hold_req + 1;
    for (int i = 0; i < 6; i++) send_word($urandom, $urandom_range(0, 1), 1'b1);
    drain();
  endtask

  task automatic test_random();
    logic [31:0] up, k;
    for (int ph = 0; ph < 8; ph++) begin
      rx_steady = (ph == 3);
      up = 32'h4000_0000 + $urandom_range(0, 32'h0200_0000);
      k = $urandom_range(32'h0010_0000, 32'h0200_0000);
      if (ph == 5) begin
        setup($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 127));
      end else begin
        setup(up, 32'h8000_0000 - (up - 32'h4000_0000), $urandom_range(0, 32'h2000_0000),
              $urandom_range(0, 32'h2000_0000), $urandom_range(32'h3F00_0000, 32'h4000_0000),
              k, $urandom_range(1, 10));
      end
      for (int i = 0; i < 12; i++) begin
        if (ph == 5 || $urandom_range(0, 3) == 0)
          send_word($urandom, $urandom_range(0, 1), ph == 3);
        else
          send_word(k + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
                    $urandom_range(0, 1), ph == 3);
      end
      drain();
    end
    rx_steady = 1'b0;
  endtask

  initial begin
    sh_up = Q30One;
    sh_down = Q30One;
    sh_pu = '0;
    sh_pd = '0;
    sh_disc = Q30One;
    sh_strike = '0;
    sh_steps = 7'd1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_directed();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
